// ===== hdl/rasmt_pkg.sv =====
// ----------------------------------------------------------------------------
// rasmt_pkg
// Shared types, constants and helpers of the range-add / max segment tree.
// ----------------------------------------------------------------------------
package rasmt_pkg;

	localparam int LEAVES    = 1024;
	localparam int POS_W     = 11;
	localparam int VAL_W     = 32;
	localparam int ADD_W     = 17;
	localparam int CMD_W     = 2;
	localparam int NODE_W    = 12;                // node index, root is 1
	localparam int IDX_W     = NODE_W - 1;        // pair index = node >> 1
	localparam int MEM_DEPTH = 1 << IDX_W;
	localparam int STK_DEPTH = 11;                // parents on the walk
	localparam int SP_W      = 4;

	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;

	localparam logic [VAL_W-1:0] REMOVED_VALUE = 32'hFFC0_0000; // -4194304

	typedef struct packed {
		logic [VAL_W-1:0] max;
		logic [VAL_W-1:0] pend;
	} node_entry_t;

	// one write port (per-half enables) and one read port on the pair memory
	typedef struct packed {
		logic             we_even;
		logic             we_odd;
		logic [IDX_W-1:0] waddr;
		node_entry_t      wdata_even;
		node_entry_t      wdata_odd;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_RD_SELF,
		ST_SELF,
		ST_RD_CH,
		ST_PUSH,
		ST_NEXT,
		ST_RET,
		ST_RD_KIDS,
		ST_REFRESH,
		ST_RD_ROOT,
		ST_ROOT
	} state_t;

	function automatic logic [VAL_W-1:0] smax(input logic [VAL_W-1:0] a,
		input logic [VAL_W-1:0] b);
		return ($signed(a) >= $signed(b)) ? a : b;
	endfunction

endpackage

// ===== hdl/range_add_max_segment_tree.sv =====
// ----------------------------------------------------------------------------
// range_add_max_segment_tree
// Lazy max segment tree with range add, point removal and global max query.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* channel takes one command item; m_* channel returns one item per
//    command carrying the global maximum after that command.
//  - cfg_we/cfg_wdata write leaf_count (positions 1..leaf_count, saturated
//    at 1024); write only while no command is in flight.
//  - One item at a time. A command walks the tree with an explicit parent
//    stack; every visited node costs a read, a write and a step, a pending
//    pushdown a child read and a child write more, and a node that splits
//    the range two returns, a child read, the refresh write and a step more.
//  - A query, an empty range or an out-of-range removal skips the walk and
//    only reads the root. The node memory (one read, one write a cycle)
//    sets the pace.
//  - After reset a clearing pass zeroes the node memory with s_tready
//    low; configuration writes are taken meanwhile.
//  - The result sits in an output register; when the receiver stalls the
//    block still accepts the next item and runs it, then holds before
//    reloading the output register until it is free.
// ----------------------------------------------------------------------------
module range_add_max_segment_tree (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,     // leaf_count
	input  logic        s_tvalid,
	output logic        s_tready,
	// [1:0] command, [12:2] range_low, [23:13] range_high,
	// [40:24] add_value, [51:41] point, [55:52] zero
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata        // [31:0] global_max
);
	import rasmt_pkg::*;

	state_t state_q, state_d;

	logic [POS_W-1:0] leaf_count_q;
	logic [IDX_W-1:0] clr_q;

	// latched command
	logic [CMD_W-1:0] cmd_q;
	logic [POS_W-1:0] lo_q, hi_q, pt_q, n_q;
	logic [ADD_W-1:0] v_q;

	// current node and its span
	logic [NODE_W-1:0] cur_q;
	logic [POS_W-1:0]  l_q, r_q;
	logic              ph_q;
	logic              descend_q;
	logic [VAL_W-1:0]  p_q;

	// parent stack
	logic [SP_W-1:0]   sp_q;
	logic [NODE_W-1:0] stk_node [STK_DEPTH];
	logic [POS_W-1:0]  stk_l    [STK_DEPTH];
	logic [POS_W-1:0]  stk_r    [STK_DEPTH];
	logic              stk_ph   [STK_DEPTH];

	mem_req_t    req;
	node_entry_t rd_even, rd_odd;

	rasmt_node_mem u_mem (
		.clk     (clk),
		.req     (req),
		.rd_even (rd_even),
		.rd_odd  (rd_odd)
	);

	// decode of the current node
	logic              is_add, is_rem, leaf, disjoint, covered, desc, push_need;
	logic              out_free, op_go;
	logic [POS_W:0]    span_sum;
	logic [POS_W-1:0]  mid;
	logic [SP_W-1:0]   sp_m1;
	logic [VAL_W-1:0]  v_ext;
	node_entry_t       self_old, self_new, kid_even, kid_odd, refr;

	assign is_add   = (cmd_q == CMD_ADD);
	assign is_rem   = (cmd_q == CMD_REMOVE);
	assign leaf     = (l_q == r_q);
	assign disjoint = (lo_q > r_q) || (l_q > hi_q);
	assign covered  = (lo_q <= l_q) && (r_q <= hi_q);
	assign span_sum = {1'b0, l_q} + {1'b0, r_q};
	assign mid      = span_sum[POS_W:1];
	assign sp_m1    = sp_q - SP_W'(1);
	assign v_ext    = {{(VAL_W-ADD_W){v_q[ADD_W-1]}}, v_q};
	assign out_free = !m_tvalid || m_tready;
	assign self_old = cur_q[0] ? rd_odd : rd_even;

	assign op_go = (n_q != '0) &&
		((is_add && (lo_q <= hi_q)) ||
		 (is_rem && (pt_q != '0) && (pt_q <= n_q)));

	always_comb begin
		self_new.max  = self_old.max;
		self_new.pend = '0;             // old pending always leaves the node
		desc          = 1'b0;
		if (is_add) begin
			if (!disjoint && covered) begin
				self_new.max  = self_old.max + v_ext;
				self_new.pend = v_ext;
			end
			desc = !disjoint && !covered;
		end else begin
			if (leaf && (pt_q == l_q)) begin
				self_new.max = REMOVED_VALUE;
			end
			desc = !leaf;
		end
	end

	assign push_need = !leaf && (self_old.pend != '0);

	assign kid_even.max  = rd_even.max + p_q;
	assign kid_even.pend = rd_even.pend + p_q;
	assign kid_odd.max   = rd_odd.max + p_q;
	assign kid_odd.pend  = rd_odd.pend + p_q;
	assign refr.max      = smax(rd_even.max, rd_odd.max);
	assign refr.pend     = '0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:   if (&clr_q) state_d = ST_IDLE;
			ST_IDLE:    if (s_tvalid) state_d = ST_START;
			ST_START:   state_d = op_go ? ST_RD_SELF : ST_RD_ROOT;
			ST_RD_SELF: state_d = ST_SELF;
			ST_SELF:    state_d = push_need ? ST_RD_CH : ST_NEXT;
			ST_RD_CH:   state_d = ST_PUSH;
			ST_PUSH:    state_d = ST_NEXT;
			ST_NEXT: begin
				if (descend_q)          state_d = ST_RD_SELF;
				else if (sp_q == '0)    state_d = ST_RD_ROOT;
				else                    state_d = ST_RET;
			end
			ST_RET:     state_d = (is_add && !ph_q) ? ST_RD_SELF : ST_RD_KIDS;
			ST_RD_KIDS: state_d = ST_REFRESH;
			ST_REFRESH: state_d = ST_NEXT;
			ST_RD_ROOT: state_d = ST_ROOT;
			ST_ROOT:    if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// memory requests and handshake
	always_comb begin
		req            = '0;
		s_tready       = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				req.we_even = 1'b1;
				req.we_odd  = 1'b1;
				req.waddr   = clr_q;
			end
			ST_IDLE:    s_tready = 1'b1;
			ST_RD_SELF: begin
				req.re    = 1'b1;
				req.raddr = cur_q[NODE_W-1:1];
			end
			ST_SELF: begin
				req.we_even    = !cur_q[0];
				req.we_odd     = cur_q[0];
				req.waddr      = cur_q[NODE_W-1:1];
				req.wdata_even = self_new;
				req.wdata_odd  = self_new;
			end
			ST_RD_CH, ST_RD_KIDS: begin
				req.re    = 1'b1;
				req.raddr = cur_q[IDX_W-1:0];
			end
			ST_PUSH: begin
				req.we_even    = 1'b1;
				req.we_odd     = 1'b1;
				req.waddr      = cur_q[IDX_W-1:0];
				req.wdata_even = kid_even;
				req.wdata_odd  = kid_odd;
			end
			ST_REFRESH: begin
				req.we_even    = !cur_q[0];
				req.we_odd     = cur_q[0];
				req.waddr      = cur_q[NODE_W-1:1];
				req.wdata_even = refr;
				req.wdata_odd  = refr;
			end
			ST_RD_ROOT: begin
				req.re    = 1'b1;
				req.raddr = '0;             // pair 0 holds the root as its odd half
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			leaf_count_q <= POS_W'(LEAVES);
			sp_q         <= '0;
			m_tvalid     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				leaf_count_q <= cfg_wdata;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (state_q == ST_START) begin
				sp_q <= '0;
			end else if (state_q == ST_NEXT) begin
				if (descend_q)        sp_q <= sp_q + SP_W'(1);
				else if (sp_q != '0)  sp_q <= sp_m1;
			end else if ((state_q == ST_RET) && is_add && !ph_q) begin
				sp_q <= sp_q + SP_W'(1);
			end
			if ((state_q == ST_ROOT) && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q <= s_tdata[1:0];
				lo_q  <= s_tdata[12:2];
				hi_q  <= s_tdata[23:13];
				v_q   <= s_tdata[40:24];
				pt_q  <= s_tdata[51:41];
				n_q   <= (leaf_count_q > POS_W'(LEAVES)) ? POS_W'(LEAVES) : leaf_count_q;
			end
			ST_START: begin
				cur_q <= NODE_W'(1);
				l_q   <= POS_W'(1);
				r_q   <= n_q;
			end
			ST_SELF: begin
				p_q       <= self_old.pend;
				descend_q <= desc;
			end
			ST_NEXT: begin
				if (descend_q) begin
					stk_node[sp_q] <= cur_q;
					stk_l[sp_q]    <= l_q;
					stk_r[sp_q]    <= r_q;
					stk_ph[sp_q]   <= !is_add;   // removal takes one child only
					if (is_rem && (pt_q > mid)) begin
						cur_q <= {cur_q[NODE_W-2:0], 1'b1};
						l_q   <= mid + POS_W'(1);
					end else begin
						cur_q <= {cur_q[NODE_W-2:0], 1'b0};
						r_q   <= mid;
					end
				end else if (sp_q != '0) begin
					cur_q <= stk_node[sp_m1];
					l_q   <= stk_l[sp_m1];
					r_q   <= stk_r[sp_m1];
					ph_q  <= stk_ph[sp_m1];
				end
			end
			ST_RET: begin
				if (is_add && !ph_q) begin
					// left subtree done, go right
					stk_node[sp_q] <= cur_q;
					stk_l[sp_q]    <= l_q;
					stk_r[sp_q]    <= r_q;
					stk_ph[sp_q]   <= 1'b1;
					cur_q          <= {cur_q[NODE_W-2:0], 1'b1};
					l_q            <= mid + POS_W'(1);
				end
			end
			ST_REFRESH: descend_q <= 1'b0;
			ST_ROOT: begin
				if (out_free) begin
					m_tdata <= rd_odd.max;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STK_DEPTH))
		else $error("parent stack overflow");

	a_push_internal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH) |-> (l_q != r_q))
		else $error("pushdown on a leaf");

	a_out_from_root: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_ROOT))
		else $error("result raised outside root read");

	a_accept_empty_stack: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_START))
		else $error("accept did not start a command");
`endif

endmodule

// ===== hdl/rasmt_node_mem.sv =====
// ----------------------------------------------------------------------------
// rasmt_node_mem
// Node storage: sibling pairs side by side, even node and odd node halves.
// ----------------------------------------------------------------------------
module rasmt_node_mem (
	input  logic                 clk,
	input  rasmt_pkg::mem_req_t  req,
	output rasmt_pkg::node_entry_t rd_even,
	output rasmt_pkg::node_entry_t rd_odd
);
	import rasmt_pkg::*;

	node_entry_t mem_even [MEM_DEPTH];
	node_entry_t mem_odd  [MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we_even) begin
			mem_even[req.waddr] <= req.wdata_even;
		end
		if (req.we_odd) begin
			mem_odd[req.waddr] <= req.wdata_odd;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_even <= mem_even[req.raddr];
			rd_odd  <= mem_odd[req.raddr];
		end
	end

endmodule

// ===== verif/range_add_max_segment_tree_chk.sv =====
// ----------------------------------------------------------------------------
// range_add_max_segment_tree_chk
// Watches the command and result streams of the segment tree. Keeps its own
// lazy max tree, works out the expected global maximum for every item taken
// and compares it with the result items in order.
// ----------------------------------------------------------------------------
module range_add_max_segment_tree_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	output int          fail_count,
	output int          max_in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	import rasmt_pkg::*;

	localparam int TREE_NODES = 4 * LEAVES;

	logic [VAL_W-1:0] tree_max  [TREE_NODES];
	logic [VAL_W-1:0] tree_pend [TREE_NODES];
	logic [10:0]      positions;
	logic [VAL_W-1:0] max_queue [$];

	assign max_in_flight = max_queue.size();

	function automatic logic [VAL_W-1:0] larger(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
		return ($signed(a) >= $signed(b)) ? a : b;
	endfunction

	function automatic void push_pending(int unsigned l, int unsigned r, int unsigned nd);
		logic [VAL_W-1:0] p;
		if (nd >= TREE_NODES) return;
		p = tree_pend[nd];
		if (p == '0) return;
		if (l != r && 2 * nd + 1 < TREE_NODES) begin
			tree_max[2*nd]    += p;
			tree_max[2*nd+1]  += p;
			tree_pend[2*nd]   += p;
			tree_pend[2*nd+1] += p;
		end
		tree_pend[nd] = '0;
	endfunction

	function automatic void pull_up(int unsigned nd);
		if (nd >= TREE_NODES || 2 * nd + 1 >= TREE_NODES) return;
		tree_max[nd] = larger(tree_max[2*nd], tree_max[2*nd+1]);
	endfunction

	function automatic void add_span(int unsigned lo, int unsigned hi, int unsigned l,
		int unsigned r, int unsigned nd, logic [VAL_W-1:0] v);
		int unsigned mid;
		if (l > r || nd >= TREE_NODES) return;
		push_pending(l, r, nd);
		if (lo > r || l > hi) return;
		if (lo <= l && r <= hi) begin
			tree_max[nd]  += v;
			tree_pend[nd] += v;
			return;
		end
		mid = l + (r - l) / 2;
		add_span(lo, hi, l, mid, 2 * nd, v);
		add_span(lo, hi, mid + 1, r, 2 * nd + 1, v);
		pull_up(nd);
	endfunction

	function automatic void knock_out(int unsigned pt, int unsigned l, int unsigned r,
		int unsigned nd);
		int unsigned mid;
		if (l > r || nd >= TREE_NODES) return;
		push_pending(l, r, nd);
		if (l == r) begin
			if (pt == l) tree_max[nd] = REMOVED_VALUE;
			return;
		end
		mid = l + (r - l) / 2;
		if (pt <= mid) knock_out(pt, l, mid, 2 * nd);
		else knock_out(pt, mid + 1, r, 2 * nd + 1);
		pull_up(nd);
	endfunction

	// apply one command, return the new root maximum
	function automatic logic [VAL_W-1:0] run_command(logic [55:0] d);
		logic [CMD_W-1:0] cmd;
		int unsigned lo, hi, pt, n;
		logic [VAL_W-1:0] v;
		cmd = d[1:0];
		lo  = 32'(d[12:2]);
		hi  = 32'(d[23:13]);
		v   = {{15{d[40]}}, d[40:24]};
		pt  = 32'(d[51:41]);
		n   = (32'(positions) > LEAVES) ? LEAVES : 32'(positions);
		if (n >= 1) begin
			if (cmd == CMD_ADD) begin
				if (lo <= hi) add_span(lo, hi, 1, n, 1, v);
			end else if (cmd == CMD_REMOVE) begin
				if (pt >= 1 && pt <= n) knock_out(pt, 1, n, 1);
			end
		end
		return tree_max[1];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [VAL_W-1:0] want;
		if (!arst_n) begin
			for (int i = 0; i < TREE_NODES; i++) begin
				tree_max[i]  = '0;
				tree_pend[i] = '0;
			end
			positions  = 11'd1024;
			fail_count = 0;
			max_queue.delete();
		end else begin
			if (cfg_we) positions = cfg_wdata;
			if (s_tvalid && s_tready) begin
				max_queue.insert(max_queue.size(), run_command(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				if (max_queue.size() == 0) begin
					$display("%0t: unexpected result item, actual %0d", $time,
						$signed(m_tdata));
					fail_count++;
				end else begin
					want = max_queue.pop_front();
					if (want !== m_tdata) begin
						$display("%0t: global_max expected %0d actual %0d", $time,
							$signed(want), $signed(m_tdata));
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// ===== verif/range_add_max_segment_tree_tb.sv =====
// ----------------------------------------------------------------------------
// range_add_max_segment_tree_tb
// Drives range adds, point removals and queries into the segment tree under
// several leaf counts and handshake pressure; the checker beside the block
// predicts every global maximum and counts mismatches.
// ----------------------------------------------------------------------------
module range_add_max_segment_tree_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rasmt_pkg::*;

	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [10:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;      // [1:0] command, [12:2] range_low, [23:13] range_high,
	                           // [40:24] add_value, [51:41] point, [55:52] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;      // [31:0] global_max
	int          fail_count;
	int          max_in_flight;

	// idle odds in percent, changed per phase
	int          send_idle_pct;
	int          recv_stall_pct;
	int unsigned live_positions;

	range_add_max_segment_tree u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	range_add_max_segment_tree_chk u_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .max_in_flight(max_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("range_add_max_segment_tree: mismatch");
		$finish;
	end

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// one item onto the command stream; returns at the falling edge after accept
	task automatic send_item(input logic [CMD_W-1:0] cmd, input int unsigned lo,
		input int unsigned hi, input logic [16:0] val, input int unsigned pt);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {4'b0, pt[10:0], val, hi[10:0], lo[10:0], cmd};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// hold off until every result is back, then let the walk settle
	task automatic drain();
		s_tvalid = 1'b0;
		while (max_in_flight != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic set_positions(input int unsigned n);
		cfg_we    = 1'b1;
		cfg_wdata = n[10:0];
		live_positions = n;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// mostly well-formed ops inside the live range, some noise outside it
	task automatic random_item();
		int unsigned pick, lo, hi, pt;
		logic [16:0] val;
		pick = $urandom_range(0, 99);
		val  = 17'($urandom);
		if ($urandom_range(0, 9) == 0) begin
			lo = $urandom_range(1, 1024);
			hi = $urandom_range(0, 1024);
			pt = $urandom_range(1, 1024);
		end else begin
			lo = $urandom_range(1, live_positions);
			hi = $urandom_range(lo, live_positions);
			pt = $urandom_range(1, live_positions);
		end
		if (pick < 60) send_item(CMD_ADD, lo, hi, val, pt);
		else if (pick < 80) send_item(CMD_REMOVE, lo, hi, val, pt);
		else send_item(CMD_QUERY, lo, hi, val, pt);
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		live_positions = 1024;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		set_positions(1024);

		// directed: extremes, every command, empty and partial ranges
		send_item(CMD_QUERY, 1, 0, 17'h0, 1);
		send_item(CMD_ADD, 1, 1024, 17'h0FFFF, 1);
		send_item(CMD_ADD, 1, 1024, 17'h10000, 1024);
		send_item(CMD_ADD, 5, 4, 17'h1FFFF, 1);            // empty range
		send_item(CMD_ADD, 1, 0, 17'h00001, 1);            // empty range
		send_item(CMD_ADD, 1024, 1024, 17'h0ABCD, 1024);
		send_item(CMD_REMOVE, 1, 0, 17'h0, 1024);          // removed leaf holds max
		send_item(CMD_ADD, 1024, 1024, 17'h0FFFF, 1);      // add still lands on it
		send_item(CMD_REMOVE, 1, 0, 17'h0, 1);
		send_item(CMD_ADD, 300, 700, 17'h1F000, 512);
		send_item(CMD_QUERY, 1024, 1024, 17'h1FFFF, 1024);
		drain();
		set_positions(1000);
		send_item(CMD_ADD, 990, 1024, 17'h07777, 1);       // range past the end
		send_item(CMD_REMOVE, 1, 0, 17'h0, 1024);          // point past the end
		send_item(CMD_REMOVE, 1, 0, 17'h0, 1000);
		send_item(CMD_ADD, 1, 1000, 17'h00010, 1);
		drain();
		set_positions(1);
		send_item(CMD_ADD, 1, 1, 17'h00003, 1);
		send_item(CMD_REMOVE, 1, 0, 17'h0, 1);
		send_item(CMD_ADD, 1, 1024, 17'h1FFFE, 2);
		send_item(CMD_REMOVE, 1, 0, 17'h0, 2);
		send_item(CMD_QUERY, 0, 0, 17'h0, 0);
		drain();

		// random phases with different pressure and tree shapes
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  set_positions(1024); end
				1: begin send_idle_pct = 87; recv_stall_pct = 0;  set_positions(7);    end
				2: begin send_idle_pct = 0;  recv_stall_pct = 87; set_positions(2);    end
				default: begin
					send_idle_pct = 19; recv_stall_pct = 19; set_positions(1000);
				end
			endcase
			for (int i = 0; i < 170; i++) begin
				random_item();
				if (i == 85) drain();
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("range_add_max_segment_tree: match");
		end else begin
			$display("range_add_max_segment_tree: mismatch");
		end
		$finish;
	end

endmodule
